### src/dvru_pkg.sv
// shared types, codes and field layout for the distance-vector route update core
package dvru_pkg;

    // field widths of the stream payloads
    localparam int NODE_W     = 5;
    localparam int COST_W     = 16;
    localparam int HOP_W      = 5;
    localparam int COUNT_W    = 6;
    localparam int FUNC_W     = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // most entries one table dump can hold
    localparam int DUMP_MAX   = 32;

    // transaction kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ELEM = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    // input tdata, highest field first
    typedef struct packed {
        logic [NODE_W-1:0] sender;
        logic              link_flag;
        logic [HOP_W-1:0]  hop;
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] node;
    } dvru_in_data_t;

    // output tdata, highest field first, zero padded to a whole word
    typedef struct packed {
        logic [5:0]        pad;
        logic [HOP_W-1:0]  hop;
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] node;
    } dvru_out_data_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINK,
        ST_DEST,
        ST_DUMP_RD,
        ST_DUMP_LOAD
    } dvru_state_t;

    // route ram port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } dvru_ram_ctl_t;

endpackage

### src/dvru_route_ram.sv
// route table ram: cost and next hop per node, registered read, per-entry valid bits
module dvru_route_ram #(
    parameter int DEPTH   = 32,
    parameter int COST_BW = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dvru_pkg::dvru_ram_ctl_t      ctl,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [COST_BW-1:0]           wr_cost,
    input  logic [dvru_pkg::HOP_W-1:0]   wr_hop,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [COST_BW-1:0]           rd_cost,
    output logic [dvru_pkg::HOP_W-1:0]   rd_hop
);

    localparam logic [COST_BW-1:0] INF_COST = '1;

    logic [COST_BW-1:0]         cost_mem [DEPTH];
    logic [dvru_pkg::HOP_W-1:0] hop_mem  [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic                       rd_valid_reg;
    logic [COST_BW-1:0]         rd_cost_reg;
    logic [dvru_pkg::HOP_W-1:0] rd_hop_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            cost_mem[wr_addr] <= wr_cost;
            hop_mem[wr_addr]  <= wr_hop;
        end
        if (ctl.rd_en)
        begin
            rd_cost_reg <= cost_mem[rd_addr];
            rd_hop_reg  <= hop_mem[rd_addr];
        end
    end

    // valid bits, cleared at reset so unwritten entries read as unreachable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // entries never written read as infinity with hop zero
    assign rd_cost = rd_valid_reg ? rd_cost_reg : INF_COST;
    assign rd_hop  = rd_valid_reg ? rd_hop_reg : '0;

endmodule

### src/distance_vector_route_update_core.sv
// Distance-vector route table core. A set-entry transaction (tuser 0) loads one
// node's cost, next hop and neighbor mark and the core stays ready. An advertised
// element (tuser 1) from a marked neighbor reads the destination's entry; on the
// first element of a vector the link cost to the sender is read and latched
// first. The sender's cost plus the advertised cost, saturated at the all-ones
// infinity, replaces the entry of a destination below node_count when smaller.
// A tick (tuser 2), or the tlast element of a vector that changed the table,
// streams the table out: node_count entries (0 read as 1, at most 32), each read
// through the single read port of the route ram, with tlast on the final entry.
// Elements from non-neighbors and unused tuser codes are dropped. node_count is
// written through cfg_we/cfg_wdata; the user must write it only while the core is
// idle, which the core itself does not enforce.
module distance_vector_route_update_core #(
    parameter int MAX_NODES = 32,
    parameter int COST_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration: node_count
    input  logic                                  cfg_we,
    input  logic [dvru_pkg::COUNT_W-1:0]          cfg_wdata,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata fields from bit 0: node, cost, hop, link_flag, sender
    input  logic [dvru_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // tuser fields from bit 0: func
    input  logic [dvru_pkg::FUNC_W-1:0]           s_axis_tuser,
    input  logic                                  s_axis_tlast,
    // output stream, tlast is end_of_table
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata fields from bit 0: out_node, out_cost, out_hop, zero pad
    output logic [dvru_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CAP   = (MAX_NODES < dvru_pkg::DUMP_MAX) ? MAX_NODES : dvru_pkg::DUMP_MAX;
    localparam logic [dvru_pkg::COUNT_W-1:0] CAP_COUNT = dvru_pkg::COUNT_W'(CAP);
    localparam logic [COST_BITS-1:0]         INF_COST  = '1;

    dvru_pkg::dvru_state_t state_reg, state_next;

    logic [dvru_pkg::NODE_W-1:0]  node_reg;
    logic [COST_BITS-1:0]         cost_reg;
    logic [dvru_pkg::NODE_W-1:0]  sender_reg;
    logic                         last_reg;
    logic [COST_BITS-1:0]         link_reg, link_next;
    logic                         mid_reg, mid_next;
    logic                         changed_reg, changed_next;
    logic [dvru_pkg::NODE_W-1:0]  cnt_reg, cnt_next;
    logic [dvru_pkg::COUNT_W-1:0] node_count_reg;
    logic [MAX_NODES-1:0]         marks_reg;

    logic                         m_valid_reg;
    logic [dvru_pkg::NODE_W-1:0]  m_node_reg;
    logic [dvru_pkg::COST_W-1:0]  m_cost_reg;
    logic [dvru_pkg::HOP_W-1:0]   m_hop_reg;
    logic                         m_last_reg;

    dvru_pkg::dvru_in_data_t      in_data;
    dvru_pkg::dvru_out_data_t     out_data;
    dvru_pkg::dvru_ram_ctl_t      ram_ctl;
    logic                         in_acc;
    logic                         mark_we;
    logic [IDX_W-1:0]             wr_addr;
    logic [COST_BITS-1:0]         wr_cost;
    logic [dvru_pkg::HOP_W-1:0]   wr_hop;
    logic [IDX_W-1:0]             rd_addr;
    logic [COST_BITS-1:0]         rd_cost;
    logic [dvru_pkg::HOP_W-1:0]   rd_hop;
    logic [dvru_pkg::COUNT_W-1:0] eff_count;
    logic [COST_BITS:0]           sum;
    logic [COST_BITS-1:0]         sum_sat;
    logic                         dest_in_range;
    logic                         relax_hit;
    logic                         sender_ok;
    logic                         dump_end;
    logic                         out_load;

    assign in_data = dvru_pkg::dvru_in_data_t'(s_axis_tdata);
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // route table storage
    dvru_route_ram #(
        .DEPTH   (MAX_NODES),
        .COST_BW (COST_BITS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_cost (wr_cost),
        .wr_hop  (wr_hop),
        .rd_addr (rd_addr),
        .rd_cost (rd_cost),
        .rd_hop  (rd_hop)
    );

    // effective node count: zero raised to one, capped at table size and dump size
    always_comb
    begin
        priority if (node_count_reg == '0)
        begin
            eff_count = dvru_pkg::COUNT_W'(1);
        end
        else if (node_count_reg > CAP_COUNT)
        begin
            eff_count = CAP_COUNT;
        end
        else
        begin
            eff_count = node_count_reg;
        end
    end

    // add, saturate and compare unit
    assign sum           = {1'b0, link_reg} + {1'b0, cost_reg};
    assign sum_sat       = (sum >= {1'b0, INF_COST}) ? INF_COST : sum[COST_BITS-1:0];
    assign dest_in_range = {1'b0, node_reg} < eff_count;
    assign relax_hit     = dest_in_range && (sum_sat < rd_cost);

    // sender must be a marked neighbor inside the table
    assign sender_ok = (32'(in_data.sender) < MAX_NODES) && marks_reg[IDX_W'(in_data.sender)];
    assign dump_end  = ({1'b0, cnt_reg} + dvru_pkg::COUNT_W'(1)) == eff_count;

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next      = state_reg;
        link_next       = link_reg;
        mid_next        = mid_reg;
        changed_next    = changed_reg;
        cnt_next        = cnt_reg;
        s_axis_tready   = 1'b0;
        ram_ctl.wr_en   = 1'b0;
        ram_ctl.rd_en   = 1'b0;
        mark_we         = 1'b0;
        wr_addr         = IDX_W'(in_data.node);
        wr_cost         = COST_BITS'(in_data.cost);
        wr_hop          = in_data.hop;
        rd_addr         = IDX_W'(node_reg);
        out_load        = 1'b0;
        unique case (state_reg)
            dvru_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    priority if (s_axis_tuser == dvru_pkg::FUNC_SET)
                    begin
                        if (32'(in_data.node) < MAX_NODES)
                        begin
                            ram_ctl.wr_en = 1'b1;
                            mark_we       = 1'b1;
                        end
                    end
                    else if (s_axis_tuser == dvru_pkg::FUNC_TICK)
                    begin
                        cnt_next   = '0;
                        state_next = dvru_pkg::ST_DUMP_RD;
                    end
                    else if (s_axis_tuser == dvru_pkg::FUNC_ELEM && sender_ok)
                    begin
                        ram_ctl.rd_en = 1'b1;
                        if (!mid_reg)
                        begin
                            rd_addr    = IDX_W'(in_data.sender);
                            state_next = dvru_pkg::ST_LINK;
                        end
                        else
                        begin
                            rd_addr    = IDX_W'(in_data.node);
                            state_next = dvru_pkg::ST_DEST;
                        end
                    end
                    else
                    begin
                        state_next = dvru_pkg::ST_IDLE;
                    end
                end
            end
            dvru_pkg::ST_LINK:
            begin
                // latch link cost, then fetch the destination entry
                link_next     = rd_cost;
                ram_ctl.rd_en = 1'b1;
                rd_addr       = IDX_W'(node_reg);
                state_next    = dvru_pkg::ST_DEST;
            end
            dvru_pkg::ST_DEST:
            begin
                wr_addr = IDX_W'(node_reg);
                wr_cost = sum_sat;
                wr_hop  = sender_reg;
                if (relax_hit)
                begin
                    ram_ctl.wr_en = 1'b1;
                end
                state_next = dvru_pkg::ST_IDLE;
                if (last_reg)
                begin
                    mid_next     = 1'b0;
                    changed_next = 1'b0;
                    if (changed_reg || relax_hit)
                    begin
                        cnt_next   = '0;
                        state_next = dvru_pkg::ST_DUMP_RD;
                    end
                end
                else
                begin
                    mid_next     = 1'b1;
                    changed_next = changed_reg || relax_hit;
                end
            end
            dvru_pkg::ST_DUMP_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = IDX_W'(cnt_reg);
                state_next    = dvru_pkg::ST_DUMP_LOAD;
            end
            dvru_pkg::ST_DUMP_LOAD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if (dump_end)
                    begin
                        state_next = dvru_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + dvru_pkg::NODE_W'(1);
                        state_next = dvru_pkg::ST_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = dvru_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dvru_pkg::ST_IDLE;
            link_reg       <= '0;
            mid_reg        <= 1'b0;
            changed_reg    <= 1'b0;
            cnt_reg        <= '0;
            node_count_reg <= dvru_pkg::COUNT_W'(32);
            marks_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            link_reg    <= link_next;
            mid_reg     <= mid_next;
            changed_reg <= changed_next;
            cnt_reg     <= cnt_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (mark_we)
            begin
                marks_reg[IDX_W'(in_data.node)] <= in_data.link_flag;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured element fields
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            node_reg   <= in_data.node;
            cost_reg   <= COST_BITS'(in_data.cost);
            sender_reg <= in_data.sender;
            last_reg   <= s_axis_tlast;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_node_reg <= cnt_reg;
            m_cost_reg <= dvru_pkg::COST_W'(rd_cost);
            m_hop_reg  <= rd_hop;
            m_last_reg <= dump_end;
        end
    end

    assign out_data.pad  = '0;
    assign out_data.hop  = m_hop_reg;
    assign out_data.cost = m_cost_reg;
    assign out_data.node = m_node_reg;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data;
    assign m_axis_tlast  = m_last_reg;

    // table writes only come from a set entry or a relaxation step
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.wr_en |-> (state_reg == dvru_pkg::ST_IDLE || state_reg == dvru_pkg::ST_DEST))
        else $error("route table written outside set entry or relaxation");

    // dump index stays inside the effective table
    a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dvru_pkg::ST_DUMP_RD || state_reg == dvru_pkg::ST_DUMP_LOAD)
        |-> ({1'b0, cnt_reg} < eff_count))
        else $error("dump index beyond node count");

    // the final entry of a dump returns the sequencer to idle
    a_dump_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && dump_end) |=> (state_reg == dvru_pkg::ST_IDLE && m_axis_tlast))
        else $error("dump did not finish after end of table");

endmodule

### tb/sv/dvru_route_checker.sv
// route table checker: predicts every table dump and compares it with the output stream
`timescale 1ns / 100ps

module dvru_route_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dvru_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // tdata fields from bit 0: node, cost, hop, link_flag, sender
    input  logic [dvru_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser fields from bit 0: func
    input  logic [dvru_pkg::FUNC_W-1:0]     s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata fields from bit 0: out_node, out_cost, out_hop, zero pad
    input  logic [dvru_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast,
    output int                              fail_count,
    output int                              entries_due
);

    localparam logic [dvru_pkg::COST_W-1:0] COST_INF    = '1;
    localparam int                          TABLE_DEPTH = 32;

    // one table entry as it leaves the block
    typedef struct packed {
        logic [dvru_pkg::NODE_W-1:0] node;
        logic [dvru_pkg::COST_W-1:0] cost;
        logic [dvru_pkg::HOP_W-1:0]  hop;
        logic                        end_of_table;
    } route_entry_t;

    // shadow copy of the route table and vector state
    logic [dvru_pkg::COST_W-1:0]  cost_tbl [TABLE_DEPTH];
    logic [dvru_pkg::HOP_W-1:0]   hop_tbl  [TABLE_DEPTH];
    logic                         nbr_mark [TABLE_DEPTH];
    logic                         dirty;
    logic [dvru_pkg::COST_W-1:0]  link_cost;
    logic                         in_vector;
    logic [dvru_pkg::COUNT_W-1:0] node_count;
    route_entry_t                 entries_q [$];

    // entries per dump: zero counts as one, capped at the dump size
    function automatic int dump_len();
        int n;
        n = int'(node_count);
        if (n == 0) n = 1;
        if (n > dvru_pkg::DUMP_MAX) n = dvru_pkg::DUMP_MAX;
        return n;
    endfunction

    // queue the whole table as expected entries
    function automatic void queue_dump();
        route_entry_t e;
        int n;
        n = dump_len();
        for (int k = 0; k < n; k++)
        begin
            e.node         = dvru_pkg::NODE_W'(k);
            e.cost         = cost_tbl[k];
            e.hop          = hop_tbl[k];
            e.end_of_table = (k == n - 1);
            entries_q.push_back(e);
        end
    endfunction

    // table update for one input transaction: entry load, tick dump or bellman-ford relaxation
    function automatic void relax_route(input dvru_pkg::dvru_in_data_t d,
                                        input logic [dvru_pkg::FUNC_W-1:0] fn,
                                        input logic lst);
        logic [dvru_pkg::COST_W:0]   sum;
        logic [dvru_pkg::COST_W-1:0] relaxed_cost;
        unique case (fn)
            dvru_pkg::FUNC_SET:
            begin
                cost_tbl[d.node] = d.cost;
                hop_tbl[d.node]  = d.hop;
                nbr_mark[d.node] = d.link_flag;
            end
            dvru_pkg::FUNC_TICK:
            begin
                queue_dump();
            end
            dvru_pkg::FUNC_ELEM:
            begin
                // elements from non-neighbors leave no trace
                if (nbr_mark[d.sender])
                begin
                    if (!in_vector) link_cost = cost_tbl[d.sender];
                    if (int'(d.node) < dump_len())
                    begin
                        sum          = {1'b0, link_cost} + {1'b0, d.cost};
                        relaxed_cost = (sum >= {1'b0, COST_INF}) ? COST_INF
                                                                 : sum[dvru_pkg::COST_W-1:0];
                        if (relaxed_cost < cost_tbl[d.node])
                        begin
                            cost_tbl[d.node] = relaxed_cost;
                            hop_tbl[d.node]  = d.sender;
                            dirty            = 1'b1;
                        end
                    end
                    // end of vector: dump only if something improved
                    if (lst)
                    begin
                        in_vector = 1'b0;
                        if (dirty)
                        begin
                            dirty = 1'b0;
                            queue_dump();
                        end
                    end
                    else
                    begin
                        in_vector = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // count a failure, show only the first ten
    function automatic void report_fail(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    // watch config, output and input transactions at each rising edge
    always @(posedge clk)
    begin : monitor
        route_entry_t             got;
        route_entry_t             want;
        dvru_pkg::dvru_out_data_t od;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                cost_tbl[i] = COST_INF;
                hop_tbl[i]  = '0;
                nbr_mark[i] = 1'b0;
            end
            dirty      = 1'b0;
            link_cost  = '0;
            in_vector  = 1'b0;
            node_count = dvru_pkg::COUNT_W'(32);
            fail_count = 0;
            entries_q.delete();
        end
        else
        begin
            if (cfg_we) node_count = cfg_wdata;
            // output side first: it can only answer earlier inputs
            if (m_axis_tvalid && m_axis_tready)
            begin
                od                = m_axis_tdata;
                got.node          = od.node;
                got.cost          = od.cost;
                got.hop           = od.hop;
                got.end_of_table  = m_axis_tlast;
                if (entries_q.size() == 0)
                begin
                    report_fail($sformatf("unexpected entry node %0d cost %0d hop %0d last %0d",
                                          got.node, got.cost, got.hop, got.end_of_table));
                end
                else
                begin
                    want = entries_q.pop_front();
                    if (got !== want)
                        report_fail($sformatf({"entry mismatch: expected node %0d cost %0d ",
                                               "hop %0d last %0d, got node %0d cost %0d ",
                                               "hop %0d last %0d"},
                                              want.node, want.cost, want.hop,
                                              want.end_of_table, got.node, got.cost,
                                              got.hop, got.end_of_table));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                relax_route(dvru_pkg::dvru_in_data_t'(s_axis_tdata), s_axis_tuser,
                            s_axis_tlast);
        end
        entries_due = entries_q.size();
    end

endmodule

### tb/sv/distance_vector_route_update_core_tb.sv
// top of the route update testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module distance_vector_route_update_core_tb;

    localparam logic [dvru_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 50;
    localparam int TAIL_CYCLES  = 12;
    localparam int PHASES       = 8;
    // node_count per random phase, phase 0 in the lowest bits
    localparam logic [PHASES*dvru_pkg::COUNT_W-1:0] PHASE_COUNTS =
        {6'd32, 6'd33, 6'd0, 6'd63, 6'd1, 6'd17, 6'd3, 6'd32};

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [dvru_pkg::COUNT_W-1:0]   cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dvru_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic [dvru_pkg::FUNC_W-1:0]    s_axis_tuser;
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dvru_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    int fail_count;
    int entries_due;
    int items_sent;
    bit calm;
    bit hold_req;
    bit nbr_seen [32];

    distance_vector_route_update_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    dvru_route_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .entries_due   (entries_due)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL distance_vector_route_update_core");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin : receiver
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // cost mix: mostly small, some zero, infinity and near saturation
    function automatic logic [dvru_pkg::COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 9);
        unique case (r)
            0:       return '0;
            1:       return '1;
            2:       return dvru_pkg::COST_W'($urandom_range(60000, 65535));
            default: return dvru_pkg::COST_W'($urandom_range(0, 3000));
        endcase
    endfunction

    // random marked neighbor, or any node if none is found
    function automatic logic [dvru_pkg::NODE_W-1:0] pick_neighbor();
        logic [dvru_pkg::NODE_W-1:0] n;
        for (int t = 0; t < 64; t++)
        begin
            n = dvru_pkg::NODE_W'($urandom_range(0, 31));
            if (nbr_seen[n]) return n;
        end
        return dvru_pkg::NODE_W'($urandom_range(0, 31));
    endfunction

    // offer one transaction, entered and left at a falling edge
    task automatic send_item(input logic [dvru_pkg::FUNC_W-1:0] fn,
                             input logic [dvru_pkg::NODE_W-1:0] nd,
                             input logic [dvru_pkg::COST_W-1:0] cs,
                             input logic [dvru_pkg::HOP_W-1:0] hp,
                             input logic lk, input logic [dvru_pkg::NODE_W-1:0] sd,
                             input logic lst);
        dvru_pkg::dvru_in_data_t d;
        int gap;
        d.node      = nd;
        d.cost      = cs;
        d.hop       = hp;
        d.link_flag = lk;
        d.sender    = sd;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= fn;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        if (fn == dvru_pkg::FUNC_SET) nbr_seen[nd] = lk;
        if (fn != FUNC_UNUSED) items_sent++;
    endtask

    // drop valid, wait for every expected entry, then let the core go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (entries_due != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // node_count write while the core is idle
    task automatic write_count(input logic [dvru_pkg::COUNT_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int r;
        int len;
        logic [dvru_pkg::NODE_W-1:0] snd;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dvru_pkg::FUNC_SET;
        s_axis_tlast  = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        for (int i = 0; i < 32; i++) nbr_seen[i] = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: full table of 32
        write_count(6'd32);
        send_item(dvru_pkg::FUNC_TICK, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);
        send_item(dvru_pkg::FUNC_SET, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);
        send_item(dvru_pkg::FUNC_SET, 5'd1, 16'd10, 5'd1, 1'b1, 5'd0, 1'b0);
        send_item(dvru_pkg::FUNC_SET, 5'd31, 16'hFFFF, 5'd31, 1'b1, 5'd31, 1'b1);
        send_item(dvru_pkg::FUNC_SET, 5'd2, 16'd100, 5'd5, 1'b1, 5'd0, 1'b0);
        // vector from node 1, link cost changes mid-vector but stays latched
        send_item(dvru_pkg::FUNC_ELEM, 5'd3, 16'd20, 5'd0, 1'b0, 5'd1, 1'b0);
        send_item(dvru_pkg::FUNC_ELEM, 5'd31, 16'hFFFF, 5'd0, 1'b0, 5'd1, 1'b0);
        send_item(dvru_pkg::FUNC_SET, 5'd1, 16'd50, 5'd1, 1'b1, 5'd0, 1'b0);
        send_item(dvru_pkg::FUNC_ELEM, 5'd4, 16'd0, 5'd0, 1'b0, 5'd1, 1'b1);
        // non-neighbor sender is dropped
        send_item(dvru_pkg::FUNC_ELEM, 5'd5, 16'd0, 5'd0, 1'b0, 5'd0, 1'b1);
        // infinite link cost, no change and no dump
        send_item(dvru_pkg::FUNC_ELEM, 5'd6, 16'd0, 5'd0, 1'b0, 5'd31, 1'b1);
        // saturation at infinity
        send_item(dvru_pkg::FUNC_ELEM, 5'd2, 16'hFFFF, 5'd0, 1'b0, 5'd2, 1'b1);
        send_item(dvru_pkg::FUNC_ELEM, 5'd0, 16'd65500, 5'd0, 1'b0, 5'd1, 1'b1);
        // improvement then destination equal to sender
        send_item(dvru_pkg::FUNC_ELEM, 5'd7, 16'd0, 5'd0, 1'b0, 5'd2, 1'b0);
        send_item(dvru_pkg::FUNC_ELEM, 5'd2, 16'd0, 5'd0, 1'b0, 5'd2, 1'b1);
        // unused code with every field bit set
        send_item(FUNC_UNUSED, 5'd31, 16'hFFFF, 5'd31, 1'b1, 5'd31, 1'b1);
        send_item(dvru_pkg::FUNC_TICK, 5'd31, 16'hFFFF, 5'd31, 1'b1, 5'd31, 1'b1);

        // short table: destination beyond node_count is skipped
        write_count(6'd4);
        send_item(dvru_pkg::FUNC_ELEM, 5'd20, 16'd0, 5'd0, 1'b0, 5'd1, 1'b0);
        send_item(dvru_pkg::FUNC_ELEM, 5'd2, 16'd0, 5'd0, 1'b0, 5'd1, 1'b1);
        send_item(dvru_pkg::FUNC_TICK, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);
        // count extremes: one, zero read as one, above the cap
        write_count(6'd1);
        send_item(dvru_pkg::FUNC_TICK, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);
        write_count(6'd0);
        send_item(dvru_pkg::FUNC_TICK, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);
        write_count(6'd63);
        send_item(dvru_pkg::FUNC_TICK, 5'd0, 16'd0, 5'd0, 1'b0, 5'd0, 1'b0);

        // random phases, each with its own node_count
        for (int p = 0; p < PHASES; p++)
        begin
            write_count(PHASE_COUNTS[p*dvru_pkg::COUNT_W +: dvru_pkg::COUNT_W]);
            if (p == 0) hold_req = 1'b1;
            if (p == PHASES - 1) calm = 1'b1;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 22)
                begin
                    // table load, mostly marking neighbors
                    send_item(dvru_pkg::FUNC_SET, dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              pick_cost(), dvru_pkg::HOP_W'($urandom_range(0, 31)),
                              $urandom_range(0, 9) < 6,
                              dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                end
                else if (r < 80)
                begin
                    // well-formed vector from one neighbor
                    snd = pick_neighbor();
                    len = $urandom_range(1, 6);
                    for (int e = 0; e < len; e++)
                        send_item(dvru_pkg::FUNC_ELEM,
                                  dvru_pkg::NODE_W'($urandom_range(0, 31)), pick_cost(),
                                  dvru_pkg::HOP_W'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)), snd, e == len - 1);
                end
                else if (r < 90)
                begin
                    send_item(dvru_pkg::FUNC_TICK, dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              pick_cost(), dvru_pkg::HOP_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)),
                              dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                end
                else
                begin
                    // noise: any code, any sender, stray last
                    send_item(dvru_pkg::FUNC_W'($urandom_range(0, 3)),
                              dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              pick_cost(), dvru_pkg::HOP_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)),
                              dvru_pkg::NODE_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        if (fail_count == 0 && entries_due == 0)
            $display("PASS distance_vector_route_update_core");
        else
            $display("FAIL distance_vector_route_update_core");
        $finish;
    end

endmodule

### files.f
src/dvru_pkg.sv
src/dvru_route_ram.sv
src/distance_vector_route_update_core.sv
tb/sv/dvru_route_checker.sv
tb/sv/distance_vector_route_update_core_tb.sv
